### hw/rtl/cmdfc_pkg.sv
// types, constants and helper functions shared by the command frame checker
package cmdfc_pkg;

  localparam int FRAME_LEN  = 32;
  localparam int MAX_TOKENS = 10;
  localparam int CNT_W      = $clog2(FRAME_LEN + 1);

  localparam logic [7:0] CHAR_ADD_MARK = 8'h2A;
  localparam logic [7:0] CHAR_XOR_MARK = 8'h5E;
  localparam logic [7:0] CHAR_SPACE    = 8'h20;

  localparam logic [7:0] START_CHAR_RST  = 8'd36;
  localparam logic [7:0] END_CHAR_RST    = 8'd13;
  localparam logic       ECHO_ENABLE_RST = 1'b0;

  localparam logic [7:0] REG_START_CHAR  = 8'd0;
  localparam logic [7:0] REG_END_CHAR    = 8'd1;
  localparam logic [7:0] REG_ECHO_ENABLE = 8'd2;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_MISMATCH = 2'd1;
  localparam logic [1:0] STATUS_TOO_MANY = 2'd2;

  localparam logic [1:0] KIND_NONE = 2'd0;
  localparam logic [1:0] KIND_ADD  = 2'd1;
  localparam logic [1:0] KIND_XOR  = 2'd2;

  typedef enum logic [1:0] {
    SCAN_TEXT    = 2'd0,
    SCAN_ADD_HEX = 2'd1,
    SCAN_XOR_HEX = 2'd2,
    SCAN_OVER    = 2'd3
  } scan_mode_t;

  typedef struct packed {
    logic [7:0] start_char;
    logic [7:0] end_char;
    logic       echo_enable;
  } cfg_regs_t;

  typedef struct packed {
    logic             in_frame;
    logic [CNT_W-1:0] char_count;
    logic [7:0]       add_sum;
    logic [7:0]       xor_sum;
    logic [3:0]       tokens_seen;
    scan_mode_t       scan_mode;
    logic             scan_ended;
    logic [1:0]       hex_digits;
    logic [7:0]       hex_value;
    logic             hex_invalid;
    logic [7:0]       first_letter;
    logic [7:0]       second_letter;
  } frame_state_t;

  typedef struct packed {
    logic       echo_valid;
    logic [7:0] echo_byte;
    logic       frame_done;
    logic [1:0] frame_status;
    logic [1:0] check_kind;
    logic [3:0] token_count;
    logic [7:0] command_first;
    logic [7:0] command_second;
    logic [7:0] sent_checksum;
    logic [7:0] local_checksum;
  } result_t;

  localparam frame_state_t FRAME_IDLE = '{
    in_frame:      1'b0,
    char_count:    '0,
    add_sum:       8'd0,
    xor_sum:       8'd0,
    tokens_seen:   4'd0,
    scan_mode:     SCAN_TEXT,
    scan_ended:    1'b0,
    hex_digits:    2'd0,
    hex_value:     8'd0,
    hex_invalid:   1'b0,
    first_letter:  8'd0,
    second_letter: 8'd0
  };

  // returns {valid, nibble}
  function automatic logic [4:0] hex_nibble(input logic [7:0] c);
    logic [7:0] d;
    d = 8'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      d = c - 8'h30;
      return {1'b1, d[3:0]};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      d = c - 8'h37;
      return {1'b1, d[3:0]};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      d = c - 8'h57;
      return {1'b1, d[3:0]};
    end
    return 5'd0;
  endfunction

endpackage

### hw/rtl/cmdfc_if.sv
// handshake channel interfaces for input bytes, results and register writes
interface cmdfc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface cmdfc_out_if;
  logic       valid;
  logic       ready;
  logic       echo_valid;
  logic [7:0] echo_byte;
  logic       frame_done;
  logic [1:0] frame_status;
  logic [1:0] check_kind;
  logic [3:0] token_count;
  logic [7:0] command_first;
  logic [7:0] command_second;
  logic [7:0] sent_checksum;
  logic [7:0] local_checksum;

  modport source (
    output valid, output echo_valid, output echo_byte, output frame_done,
    output frame_status, output check_kind, output token_count,
    output command_first, output command_second, output sent_checksum,
    output local_checksum, input ready
  );
  modport sink (
    input valid, input echo_valid, input echo_byte, input frame_done,
    input frame_status, input check_kind, input token_count,
    input command_first, input command_second, input sent_checksum,
    input local_checksum, output ready
  );
endinterface

interface cmdfc_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] index;
  logic [7:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

### hw/rtl/command_frame_checker.sv
// command frame checker top level: registers, handshakes and checks
// One received byte is taken per cycle while in_ch.ready is high, and gives exactly one result
// item in the next cycle. A byte is taken whenever the output register is empty or its item is
// being taken in the same cycle, so the sustained rate is one item per clock while the receiver
// keeps ready high; the single result register is the only register on the path. Frame state (sums, counters, hex
// field, command letters) updates in the same cycle the byte is taken. Register
// writes are always ready and take effect on the next byte; write them only
// while no item is outstanding.
module command_frame_checker import cmdfc_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  cmdfc_in_if.sink           in_ch,
  cmdfc_out_if.source        out_ch,
  cmdfc_cfg_if.sink          cfg_ch
);

  cfg_regs_t    cfg_r;
  frame_state_t state_r;
  frame_state_t state_nxt;
  result_t      res_r;
  result_t      res_nxt;
  logic         out_valid_r;
  logic         in_fire;

  assign in_ch.ready  = !out_valid_r || out_ch.ready;
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  cmdfc_step u_step (
    .state_cur (state_r),
    .cfg       (cfg_r),
    .rx_byte   (in_ch.rx_byte),
    .state_nxt (state_nxt),
    .res_nxt   (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_char  <= START_CHAR_RST;
      cfg_r.end_char    <= END_CHAR_RST;
      cfg_r.echo_enable <= ECHO_ENABLE_RST;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        REG_START_CHAR:  cfg_r.start_char  <= cfg_ch.data;
        REG_END_CHAR:    cfg_r.end_char    <= cfg_ch.data;
        REG_ECHO_ENABLE: cfg_r.echo_enable <= cfg_ch.data[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= FRAME_IDLE;
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      state_r     <= state_nxt;
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      res_r <= res_nxt;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.echo_valid     = res_r.echo_valid;
  assign out_ch.echo_byte      = res_r.echo_byte;
  assign out_ch.frame_done     = res_r.frame_done;
  assign out_ch.frame_status   = res_r.frame_status;
  assign out_ch.check_kind     = res_r.check_kind;
  assign out_ch.token_count    = res_r.token_count;
  assign out_ch.command_first  = res_r.command_first;
  assign out_ch.command_second = res_r.command_second;
  assign out_ch.sent_checksum  = res_r.sent_checksum;
  assign out_ch.local_checksum = res_r.local_checksum;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.char_count <= CNT_W'(FRAME_LEN))
    else $error("frame byte count beyond frame length");

  a_idle_clear: assert property (@(posedge clk) disable iff (!rst_n)
    !state_r.in_frame |-> (state_r.char_count == '0 && state_r.tokens_seen == 4'd0))
    else $error("frame state not cleared outside a frame");

  a_over_ends: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.scan_mode == SCAN_OVER |-> state_r.scan_ended)
    else $error("too many arguments without end of scanning");

  a_reject_tokens: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && res_r.frame_done && res_r.frame_status != STATUS_OK)
      |-> res_r.token_count == 4'd0)
    else $error("rejected frame reports tokens");

  a_fire_valid: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> out_valid_r)
    else $error("accepted byte gave no result");

endmodule

### hw/rtl/cmdfc_step.sv
// per-byte frame parser: next frame state and result from current state and byte
module cmdfc_step import cmdfc_pkg::*; (
  input  frame_state_t state_cur,
  input  cfg_regs_t    cfg,
  input  logic [7:0]   rx_byte,
  output frame_state_t state_nxt,
  output result_t      res_nxt
);

  logic [4:0] hex_d;
  logic [7:0] sent;
  logic [7:0] local_sum;
  logic [1:0] status;
  logic [1:0] kind;

  assign hex_d = hex_nibble(rx_byte);

  // verdict for a closing byte
  always_comb begin
    sent = state_cur.hex_invalid ? 8'd0 : state_cur.hex_value;
    if (state_cur.scan_mode == SCAN_OVER) begin
      status    = STATUS_TOO_MANY;
      kind      = KIND_NONE;
      sent      = 8'd0;
      local_sum = state_cur.add_sum;
    end else begin
      kind      = 2'(state_cur.scan_mode);
      local_sum = (kind == KIND_XOR) ? state_cur.xor_sum : state_cur.add_sum;
      status    = (kind == KIND_NONE || sent == local_sum) ? STATUS_OK : STATUS_MISMATCH;
    end
  end

  always_comb begin
    state_nxt          = state_cur;
    res_nxt            = '0;
    res_nxt.echo_valid = cfg.echo_enable;
    res_nxt.echo_byte  = cfg.echo_enable ? rx_byte : 8'd0;

    if (rx_byte == cfg.start_char) begin
      state_nxt             = FRAME_IDLE;
      state_nxt.in_frame    = 1'b1;
      state_nxt.char_count  = CNT_W'(1);
      state_nxt.add_sum     = cfg.start_char;
      state_nxt.xor_sum     = cfg.start_char;
      state_nxt.tokens_seen = 4'd1;
    end else if (state_cur.in_frame) begin
      if (state_cur.char_count >= CNT_W'(FRAME_LEN)) begin
        state_nxt = FRAME_IDLE;
      end else if (rx_byte == cfg.end_char) begin
        res_nxt.frame_done     = 1'b1;
        res_nxt.frame_status   = status;
        res_nxt.check_kind     = kind;
        res_nxt.token_count    = (status == STATUS_OK) ? state_cur.tokens_seen : 4'd0;
        res_nxt.command_first  = state_cur.first_letter;
        res_nxt.command_second = state_cur.second_letter;
        res_nxt.sent_checksum  = sent;
        res_nxt.local_checksum = local_sum;
        state_nxt              = FRAME_IDLE;
      end else begin
        state_nxt.char_count = state_cur.char_count + CNT_W'(1);
        if (state_cur.char_count == CNT_W'(1)) begin
          // first text byte is summed and kept as the first command letter; only a zero byte ends scanning
          state_nxt.first_letter = rx_byte;
          state_nxt.add_sum      = state_cur.add_sum + rx_byte;
          state_nxt.xor_sum      = state_cur.xor_sum ^ rx_byte;
          if (rx_byte == 8'd0) begin
            state_nxt.scan_ended = 1'b1;
          end
        end else if (!state_cur.scan_ended) begin
          if (rx_byte == 8'd0) begin
            state_nxt.scan_ended = 1'b1;
          end else begin
            case (state_cur.scan_mode)
              SCAN_TEXT: begin
                if (rx_byte == CHAR_SPACE) begin
                  if (state_cur.tokens_seen >= 4'(MAX_TOKENS)) begin
                    state_nxt.scan_mode  = SCAN_OVER;
                    state_nxt.scan_ended = 1'b1;
                  end else begin
                    state_nxt.add_sum     = state_cur.add_sum + rx_byte;
                    state_nxt.xor_sum     = state_cur.xor_sum ^ rx_byte;
                    state_nxt.tokens_seen = state_cur.tokens_seen + 4'd1;
                  end
                end else if (rx_byte == CHAR_ADD_MARK) begin
                  state_nxt.scan_mode = SCAN_ADD_HEX;
                end else if (rx_byte == CHAR_XOR_MARK) begin
                  state_nxt.scan_mode = SCAN_XOR_HEX;
                end else begin
                  if (state_cur.char_count == CNT_W'(2) && state_cur.tokens_seen == 4'd1) begin
                    state_nxt.second_letter = rx_byte;
                  end
                  state_nxt.add_sum = state_cur.add_sum + rx_byte;
                  state_nxt.xor_sum = state_cur.xor_sum ^ rx_byte;
                end
              end
              SCAN_ADD_HEX, SCAN_XOR_HEX: begin
                if (state_cur.hex_digits < 2'd2) begin
                  if (!hex_d[4]) begin
                    state_nxt.hex_invalid = 1'b1;
                    state_nxt.scan_ended  = 1'b1;
                  end else begin
                    if (state_cur.hex_digits == 2'd1) begin
                      state_nxt.hex_value = {state_cur.hex_value[3:0], hex_d[3:0]};
                    end else begin
                      state_nxt.hex_value = {4'd0, hex_d[3:0]};
                    end
                    state_nxt.hex_digits = state_cur.hex_digits + 2'd1;
                  end
                end
              end
              default: begin
              end
            endcase
          end
        end
      end
    end
  end

endmodule

### verif/command_frame_checker_test.sv
// testbench for the command frame checker: directed and random byte streams with a predictor
`timescale 1ns / 100ps

module command_frame_checker_test import cmdfc_pkg::*; ();

  localparam int         CYCLE_LIMIT = 1_000_000;
  localparam int         HOLD_CYCLES = 300;
  localparam int         TOTAL_ITEMS = 1400;
  localparam logic [7:0] REG_NONE    = 8'hFF;

  typedef enum int {BREAK_NOISE, BREAK_OVERFLOW, BREAK_ZERO, BREAK_CUT} break_kind_t;

  class verdict_board;
    logic [7:0] start_ch;
    logic [7:0] end_ch;
    logic       echo_on;
    logic       open;
    logic [5:0] held;
    logic [7:0] add_sum;
    logic [7:0] xor_sum;
    logic [3:0] tokens;
    scan_mode_t mode;
    logic       halted;
    logic [1:0] digits;
    logic [7:0] hex_acc;
    logic       hex_bad;
    logic [7:0] cmd_first;
    logic [7:0] cmd_second;
    result_t    verdicts[$];
    int         errors;

    function new();
      start_ch = START_CHAR_RST;
      end_ch   = END_CHAR_RST;
      echo_on  = ECHO_ENABLE_RST;
      errors   = 0;
      drop_frame();
    endfunction

    function void drop_frame();
      open       = 1'b0;
      held       = 6'd0;
      add_sum    = 8'd0;
      xor_sum    = 8'd0;
      tokens     = 4'd0;
      mode       = SCAN_TEXT;
      halted     = 1'b0;
      digits     = 2'd0;
      hex_acc    = 8'd0;
      hex_bad    = 1'b0;
      cmd_first  = 8'd0;
      cmd_second = 8'd0;
    endfunction

    function void write_reg(logic [7:0] idx, logic [7:0] val);
      case (idx)
        REG_START_CHAR:  start_ch = val;
        REG_END_CHAR:    end_ch = val;
        REG_ECHO_ENABLE: echo_on = val[0];
        default: ;
      endcase
    endfunction

    function void scan_char(logic [7:0] c);
      logic       ok;
      logic [3:0] nib;
      ok  = 1'b0;
      nib = 4'd0;
      if (held == 6'd1) begin
        // first text byte goes into the sums whatever it is
        cmd_first = c;
        add_sum += c;
        xor_sum ^= c;
        if (c == 8'h00) halted = 1'b1;
        return;
      end
      if (halted) return;
      if (c == 8'h00) begin
        halted = 1'b1;
        return;
      end
      case (mode)
        SCAN_TEXT: begin
          if (c == CHAR_SPACE) begin
            if (tokens >= MAX_TOKENS) begin
              mode   = SCAN_OVER;
              halted = 1'b1;
            end else begin
              add_sum += c;
              xor_sum ^= c;
              tokens  += 4'd1;
            end
          end else if (c == CHAR_ADD_MARK) begin
            mode = SCAN_ADD_HEX;
          end else if (c == CHAR_XOR_MARK) begin
            mode = SCAN_XOR_HEX;
          end else begin
            if (held == 6'd2 && tokens == 4'd1) cmd_second = c;
            add_sum += c;
            xor_sum ^= c;
          end
        end
        SCAN_ADD_HEX, SCAN_XOR_HEX: begin
          if (digits < 2'd2) begin
            if (c >= 8'h30 && c <= 8'h39) begin
              ok  = 1'b1;
              nib = c[3:0];
            end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
              ok  = 1'b1;
              nib = c[3:0] + 4'd9;
            end
            if (!ok) begin
              hex_bad = 1'b1;
              halted  = 1'b1;
            end else begin
              if (digits == 2'd1) hex_acc = hex_acc << 4;
              hex_acc += {4'd0, nib};
              digits  += 2'd1;
            end
          end
        end
        default: ;
      endcase
    endfunction

    function void note_byte(logic [7:0] c);
      result_t    r;
      logic [7:0] sent;
      r = '0;
      r.echo_valid = echo_on;
      r.echo_byte  = echo_on ? c : 8'h00;
      if (c == start_ch) begin
        drop_frame();
        open    = 1'b1;
        held    = 6'd1;
        add_sum = start_ch;
        xor_sum = start_ch;
        tokens  = 4'd1;
      end else if (open) begin
        if (held >= FRAME_LEN) begin
          drop_frame();
        end else if (c == end_ch) begin
          sent = hex_bad ? 8'h00 : hex_acc;
          r.frame_done     = 1'b1;
          r.command_first  = cmd_first;
          r.command_second = cmd_second;
          if (mode == SCAN_OVER) begin
            r.frame_status   = STATUS_TOO_MANY;
            r.check_kind     = KIND_NONE;
            r.sent_checksum  = 8'h00;
            r.local_checksum = add_sum;
          end else begin
            r.check_kind = (mode == SCAN_ADD_HEX) ? KIND_ADD :
                           (mode == SCAN_XOR_HEX) ? KIND_XOR : KIND_NONE;
            r.local_checksum = (mode == SCAN_XOR_HEX) ? xor_sum : add_sum;
            r.sent_checksum  = sent;
            r.frame_status   = (mode == SCAN_TEXT || sent == r.local_checksum) ?
                               STATUS_OK : STATUS_MISMATCH;
          end
          r.token_count = (r.frame_status == STATUS_OK) ? tokens : 4'd0;
          drop_frame();
        end else begin
          scan_char(c);
          held += 6'd1;
        end
      end
      verdicts.push_back(r);
    endfunction

    function void compare(string field, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        $display("%0t: %s expected %0h actual %0h", $time, field, want, got);
        errors++;
      end
    endfunction

    function void check_verdict(result_t got);
      result_t want;
      if (verdicts.size() == 0) begin
        $display("%0t: result item with nothing expected", $time);
        errors++;
        return;
      end
      want = verdicts.pop_front();
      compare("echo_valid", want.echo_valid, got.echo_valid);
      compare("echo_byte", want.echo_byte, got.echo_byte);
      compare("frame_done", want.frame_done, got.frame_done);
      compare("frame_status", want.frame_status, got.frame_status);
      compare("check_kind", want.check_kind, got.check_kind);
      compare("token_count", want.token_count, got.token_count);
      compare("command_first", want.command_first, got.command_first);
      compare("command_second", want.command_second, got.command_second);
      compare("sent_checksum", want.sent_checksum, got.sent_checksum);
      compare("local_checksum", want.local_checksum, got.local_checksum);
    endfunction
  endclass

  logic         clk = 1'b0;
  logic         rst_n;
  int           cycles = 0;
  int           fed;
  logic         calm;
  logic         hold_req;
  logic [7:0]   frame_open_char;
  logic [7:0]   frame_close_char;
  logic [7:0]   directed[$];
  verdict_board sb;

  cmdfc_in_if  in_ch();
  cmdfc_out_if out_ch();
  cmdfc_cfg_if cfg_ch();

  command_frame_checker dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("command_frame_checker: mismatch");
      $finish;
    end
  end

  always @(posedge clk) begin
    result_t seen;
    if (rst_n) begin
      if (cfg_ch.valid && cfg_ch.ready) sb.write_reg(cfg_ch.index, cfg_ch.data);
      if (in_ch.valid && in_ch.ready) sb.note_byte(in_ch.rx_byte);
      if (out_ch.valid && out_ch.ready) begin
        seen.echo_valid     = out_ch.echo_valid;
        seen.echo_byte      = out_ch.echo_byte;
        seen.frame_done     = out_ch.frame_done;
        seen.frame_status   = out_ch.frame_status;
        seen.check_kind     = out_ch.check_kind;
        seen.token_count    = out_ch.token_count;
        seen.command_first  = out_ch.command_first;
        seen.command_second = out_ch.command_second;
        seen.sent_checksum  = out_ch.sent_checksum;
        seen.local_checksum = out_ch.local_checksum;
        sb.check_verdict(seen);
      end
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 87) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [7:0] pick_text();
    logic [7:0] c;
    do begin
      c = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(1, 255)) :
                                        8'($urandom_range(8'h21, 8'h7E));
    end while (c == frame_open_char || c == frame_close_char || c == CHAR_SPACE ||
               c == CHAR_ADD_MARK || c == CHAR_XOR_MARK || c == 8'h00);
    return c;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    if (n < 4'd10) return 8'h30 + 8'(n);
    return ($urandom_range(0, 1) ? 8'h61 : 8'h41) + 8'(n) - 8'd10;
  endfunction

  // receiver: random stalls, plus one long hold on request
  initial begin
    int gap;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else begin
        gap = pick_gap();
        out_ch.ready <= (gap == 0);
        if (gap > 1) repeat (gap - 1) @(negedge clk);
      end
    end
  end

  task automatic push_byte(input logic [7:0] b);
    int gap;
    in_ch.valid   <= 1'b1;
    in_ch.rx_byte <= b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    fed++;
    @(negedge clk);
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic push_text(input logic [7:0] c, inout logic [7:0] asum,
                           inout logic [7:0] xsum, inout int len);
    push_byte(c);
    asum += c;
    xsum ^= c;
    len++;
  endtask

  task automatic set_reg(input logic [7:0] idx, input logic [7:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic configure(input logic [7:0] open_c, input logic [7:0] close_c,
                           input logic echo);
    set_reg(REG_START_CHAR, open_c);
    set_reg(REG_END_CHAR, close_c);
    set_reg(REG_ECHO_ENABLE, {7'd0, echo});
    cfg_ch.valid <= 1'b0;
    frame_open_char  = open_c;
    frame_close_char = close_c;
  endtask

  task automatic settle();
    in_ch.valid <= 1'b0;
    while (sb.verdicts.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic run_phase(input int items);
    logic [7:0]  asum, xsum, chk, c;
    logic [1:0]  kind;
    int          goal, len, args, pick, saved;
    break_kind_t brk;
    goal = fed + items;
    while (fed < goal) begin
      if ($urandom_range(0, 99) < 72) begin
        push_byte(frame_open_char);
        asum = frame_open_char;
        xsum = frame_open_char;
        len  = 1;
        repeat ($urandom_range(1, 3)) push_text(pick_text(), asum, xsum, len);
        args = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 12) : $urandom_range(0, 4);
        for (int i = 0; i < args && len <= 23; i++) begin
          push_text(CHAR_SPACE, asum, xsum, len);
          repeat (args > 8 ? $urandom_range(0, 1) : $urandom_range(1, 3))
            push_text(pick_text(), asum, xsum, len);
        end
        kind = 2'($urandom_range(0, 2));
        if (kind != KIND_NONE) begin
          push_byte(kind == KIND_ADD ? CHAR_ADD_MARK : CHAR_XOR_MARK);
          chk  = (kind == KIND_ADD) ? asum : xsum;
          pick = $urandom_range(0, 99);
          if (pick >= 75 && pick < 83) chk = chk ^ 8'($urandom_range(1, 255));
          if (pick < 83 || (pick >= 94 && pick < 97)) begin
            push_byte(hex_char(chk[7:4]));
            push_byte(hex_char(chk[3:0]));
            if (pick >= 94) push_byte(hex_char(4'($urandom_range(0, 15))));
          end else if (pick < 90) begin
            push_byte(hex_char(chk[3:0]));
          end else if (pick >= 97) begin
            c = 8'($urandom_range(8'h67, 8'h7A));
            if ($urandom_range(0, 1)) push_byte(hex_char(chk[7:4]));
            push_byte(c);
          end
        end
        push_byte(frame_close_char);
      end else begin
        brk   = break_kind_t'($urandom_range(0, 3));
        saved = fed;
        if (brk != BREAK_NOISE) push_byte(frame_open_char);
        case (brk)
          BREAK_NOISE: begin
            // stray bytes mostly fall outside any frame, so they are not counted
            repeat ($urandom_range(1, 8)) push_byte(8'($urandom_range(0, 255)));
            fed = saved;
          end
          BREAK_OVERFLOW: repeat ($urandom_range(30, 36)) push_byte(pick_text());
          BREAK_ZERO: begin
            repeat ($urandom_range(0, 4)) push_byte(pick_text());
            push_byte(8'h00);
            repeat ($urandom_range(0, 4)) push_byte(pick_text());
          end
          default: repeat ($urandom_range(1, 6)) push_byte(pick_text());
        endcase
        if (brk == BREAK_OVERFLOW || brk == BREAK_ZERO) push_byte(frame_close_char);
      end
    end
  endtask

  initial begin
    sb = new();
    rst_n         = 1'b0;
    in_ch.valid   = 1'b0;
    in_ch.rx_byte = 8'h00;
    cfg_ch.valid  = 1'b0;
    cfg_ch.index  = 8'h00;
    cfg_ch.data   = 8'h00;
    calm          = 1'b0;
    hold_req      = 1'b0;
    fed           = 0;
    frame_open_char  = START_CHAR_RST;
    frame_close_char = END_CHAR_RST;
    directed = '{8'h00, 8'hFF,
                 START_CHAR_RST, "Z", "Q", CHAR_XOR_MARK, "0", END_CHAR_RST,
                 START_CHAR_RST, CHAR_ADD_MARK, CHAR_XOR_MARK, "G", END_CHAR_RST,
                 START_CHAR_RST, 8'h00, "A", END_CHAR_RST,
                 START_CHAR_RST, "A", CHAR_ADD_MARK, END_CHAR_RST,
                 START_CHAR_RST, "B", CHAR_ADD_MARK, "6", "6", "1", END_CHAR_RST};
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // short hex, marker as first text byte, bad digit, leading zero, empty and long hex
    foreach (directed[i]) push_byte(directed[i]);
    settle();

    configure("#", 8'h0A, 1'b1);
    run_phase(270);
    settle();

    // long receiver hold so the block backs up
    configure(8'h00, 8'hFF, 1'b0);
    hold_req = 1'b1;
    run_phase(270);
    settle();

    calm = 1'b1;
    configure(8'hFF, 8'h00, 1'b1);
    run_phase(270);
    settle();
    calm = 1'b0;

    // same byte as start and end character; the start check wins, so it never closes a frame
    configure("@", "@", 1'b1);
    run_phase(200);
    settle();

    set_reg(REG_NONE, 8'h5A);
    configure(START_CHAR_RST, END_CHAR_RST, 1'b0);
    run_phase(TOTAL_ITEMS - fed);
    settle();

    if (sb.errors == 0 && sb.verdicts.size() == 0) begin
      $display("command_frame_checker: match");
    end else begin
      $display("command_frame_checker: mismatch");
    end
    $finish;
  end

endmodule
